@@ hw/rtl/cmpb_pkg.sv @@
// ============================================================================
// cmpb_pkg
// Shared constants and types for the color map pixel blend block.
// ============================================================================
`default_nettype none

package cmpb_pkg;

    localparam int PIX_W   = 32;
    localparam int COV_W   = 8;
    localparam int OPA_W   = 9;
    localparam int COLOR_W = 24;
    localparam int IDX_W   = 8;
    localparam int LANES   = 4;

    localparam logic [OPA_W-1:0] OPA_FULL   = 9'h100;
    localparam logic [COV_W-1:0] COV_MAX_65 = 8'd64;
    localparam logic [8:0]       ALPHA_FULL = 9'h100;

    typedef enum logic [IDX_W-1:0] {
        REG_FILL_COLOR = 8'd0,
        REG_SCALE_MODE = 8'd1,
        REG_ALPHA_MODE = 8'd2,
        REG_OPACITY    = 8'd3
    } cfg_index_t;

    // saturate a signed intermediate to one channel byte
    function automatic logic [7:0] clamp_byte(input logic signed [18:0] v);
        logic [7:0] r;
        if (v < 0)
            r = 8'd0;
        else if (v > 19'sd255)
            r = 8'hff;
        else
            r = v[7:0];
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/color_map_pixel_blend.sv @@
// Throughput: one pixel per cycle; the three-stage pipeline (coverage scale,
// channel multiplies, shift/add/clamp) stalls only on output backpressure.
// Reset: rst_n asynchronous, active low; clears pipeline valid bits and loads
// fill_color=0, scale_mode=0, alpha_mode=0, opacity=256.
// ============================================================================
// color_map_pixel_blend
// Blends a constant fill color into ARGB pixels weighted by coverage.
// ============================================================================
`default_nettype none

module color_map_pixel_blend
    import cmpb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [IDX_W-1:0]     cfg_index,
    input  wire logic [COLOR_W-1:0]   cfg_data,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [39:0]          s_tdata,   // dest_pixel[31:0], coverage[39:32]
    input  wire logic                 s_tlast,   // last_in

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [PIX_W-1:0]          m_tdata,   // result_pixel[31:0]
    output logic                      m_tlast    // last_out
);

    // configuration
    logic [COLOR_W-1:0] fill_color_reg;
    logic               scale_mode_reg;
    logic               alpha_mode_reg;
    logic [OPA_W-1:0]   opacity_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_color_reg <= '0;
            scale_mode_reg <= 1'b0;
            alpha_mode_reg <= 1'b0;
            opacity_reg    <= OPA_FULL;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FILL_COLOR: fill_color_reg <= cfg_data;
                REG_SCALE_MODE: scale_mode_reg <= cfg_data[0];
                REG_ALPHA_MODE: alpha_mode_reg <= cfg_data[0];
                REG_OPACITY:    opacity_reg    <= cfg_data[OPA_W-1:0];
                default:        ;
            endcase
        end
    end

    // pipeline control: a stage loads when empty or when its beat moves on
    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    assign en3      = ~v3_reg | m_tready;
    assign en2      = ~v2_reg | en3;
    assign en1      = ~v1_reg | en2;
    assign s_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= s_tvalid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    // stage 1: effective coverage
    logic [OPA_W-1:0]       opa;
    logic [COV_W+OPA_W-1:0] cov_prod;
    logic [COV_W-1:0]       s_next;
    logic [COV_W-1:0]       s_reg;
    logic [PIX_W-1:0]       dest1_reg;
    logic                   last1_reg;

    always_comb
    begin
        opa      = (opacity_reg > OPA_FULL) ? OPA_FULL : opacity_reg;
        cov_prod = (COV_W+OPA_W)'(s_tdata[39:32]) * (COV_W+OPA_W)'(opa);
        s_next   = cov_prod[15:8];
        if (!scale_mode_reg && (s_next > COV_MAX_65))
            s_next = COV_MAX_65;
    end

    always_ff @(posedge clk)
    begin
        if (en1 && s_tvalid)
        begin
            s_reg     <= s_next;
            dest1_reg <= s_tdata[31:0];
            last1_reg <= s_tlast;
        end
    end

    // stage 2: per-lane products
    logic [15:0]        pd_next [LANES];
    logic [16:0]        pc_next [LANES];
    logic signed [18:0] sd_next [LANES];
    logic [15:0]        pd_reg  [LANES];
    logic [16:0]        pc_reg  [LANES];
    logic signed [18:0] sd_reg  [LANES];
    logic [7:0]         dv_reg  [LANES];
    logic               last2_reg;

    always_comb
    begin
        logic [7:0]         dv;
        logic [8:0]         cv;
        logic signed [9:0]  diff;
        for (int i = 0; i < LANES; i++)
        begin
            dv = dest1_reg[8*i +: 8];
            cv = (i == LANES-1) ? ALPHA_FULL : {1'b0, fill_color_reg[8*(i%3) +: 8]};
            diff       = signed'({2'b00, cv[7:0]} | {1'b0, cv[8], 8'h00})
                         - signed'({2'b00, dv});
            pd_next[i] = 16'(dv) * 16'(s_reg);
            pc_next[i] = 17'(cv) * 17'(s_reg);
            sd_next[i] = 19'(diff) * signed'({11'd0, s_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                pd_reg[i] <= pd_next[i];
                pc_reg[i] <= pc_next[i];
                sd_reg[i] <= sd_next[i];
                dv_reg[i] <= dest1_reg[8*i +: 8];
            end
            last2_reg <= last1_reg;
        end
    end

    // stage 3: shift, add, clamp or wrap
    logic [PIX_W-1:0] res_next;
    logic [PIX_W-1:0] res_reg;
    logic             last3_reg;

    always_comb
    begin
        logic signed [18:0] prem_v;
        logic signed [18:0] st_v;
        logic [15:0]        pd_sh;
        logic [16:0]        pc_sh;
        logic signed [18:0] sd_sh;
        res_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            pd_sh  = scale_mode_reg ? (pd_reg[i] >> 8) : (pd_reg[i] >> 6);
            pc_sh  = scale_mode_reg ? (pc_reg[i] >> 8) : (pc_reg[i] >> 6);
            sd_sh  = scale_mode_reg ? (sd_reg[i] >>> 8) : (sd_reg[i] >>> 6);
            prem_v = signed'(19'(dv_reg[i])) - signed'(19'(pd_sh)) + signed'(19'(pc_sh));
            st_v   = signed'(19'(dv_reg[i])) + sd_sh;
            if (alpha_mode_reg)
                res_next[8*i +: 8] = clamp_byte(prem_v);
            else if (i == LANES-1)
                res_next[8*i +: 8] = 8'd0;
            else if (scale_mode_reg)
                res_next[8*i +: 8] = st_v[7:0];
            else
                res_next[8*i +: 8] = clamp_byte(st_v);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            res_reg   <= res_next;
            last3_reg <= last2_reg;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = res_reg;
    assign m_tlast  = last3_reg;

endmodule

`default_nettype wire
